@@ design/escape_coded_channel_mux_unit_macros.svh @@
// Assertion macros shared by the escape-coded channel mux modules.
`ifndef ESCAPE_CODED_CHANNEL_MUX_UNIT_MACROS_SVH
`define ESCAPE_CODED_CHANNEL_MUX_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ECM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ECM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ecm_pkg.sv @@
// Package: types, codes and constants of the escape-coded channel mux.
package ecm_pkg;

    localparam int ECM_MAX_OUT     = 4;
    localparam int ECM_IDX_W       = $clog2(ECM_MAX_OUT);
    localparam int ECM_QUEUE_DEPTH = 2;
    localparam int ECM_CFG_IDX_W   = 3;
    localparam int ECM_CFG_DATA_W  = 64;

    localparam logic [7:0] ECM_ESC_BYTE     = 8'hFF;
    localparam logic [7:0] ECM_LITERAL_CODE = 8'hFE;
    localparam logic [7:0] ECM_QUERY_CODE   = 8'hFD;
    localparam logic [7:0] ECM_MAX_CHANNEL  = 8'hFE;

    typedef enum logic [1:0] {
        CMD_RECEIVE = 2'd0,
        CMD_SEND    = 2'd1,
        CMD_SYNC    = 2'd2
    } t_cmd;

    typedef enum logic [ECM_CFG_IDX_W-1:0] {
        CFG_V2_PROTOCOL   = 3'd0,
        CFG_WAIT_FOR_SYNC = 3'd1,
        CFG_INITIAL_RX    = 3'd2,
        CFG_ENABLED_0     = 3'd3,
        CFG_ENABLED_1     = 3'd4,
        CFG_ENABLED_2     = 3'd5,
        CFG_ENABLED_3     = 3'd6
    } t_cfg_idx;

    // One decoded item: up to four bytes that share destination and channels.
    typedef struct packed {
        logic [ECM_MAX_OUT-1:0][7:0] bytes;
        logic [ECM_IDX_W-1:0]        last;
        logic                        dest;
        logic [7:0]                  target;
        logic [7:0]                  rxch;
    } t_job;

endpackage

@@ design/ecm_front.sv @@
// Front end: configuration registers, link state and decoding of each word into at most one job.
module ecm_front
    import ecm_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [1:0]                i_command,
    input  logic [7:0]                i_data_byte,
    input  logic [7:0]                i_source_channel,
    input  logic                      i_cfg_write,
    input  logic [ECM_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ECM_CFG_DATA_W-1:0] i_cfg_data,
    output logic                      o_push,
    output t_job                      o_job
);

    logic         r_v2;
    logic         r_wait;
    logic [254:0] r_enabled;

    logic         r_esc;
    logic         r_synced;
    logic [7:0]   r_rx;
    logic [7:0]   r_tx;
    logic         r_known;

    logic         n_esc;
    logic         n_synced;
    logic [7:0]   n_rx;
    logic [7:0]   n_tx;
    logic         n_known;

    logic [255:0] enabled_vec;
    logic [7:0]   limit;
    logic         has_result;
    t_job         job;
    logic [7:0]   cfg_rx;

    assign enabled_vec = {1'b0, r_enabled};
    assign limit       = r_v2 ? ECM_QUERY_CODE : ECM_LITERAL_CODE;
    assign cfg_rx      = (i_cfg_data[7:0] == ECM_ESC_BYTE) ? ECM_MAX_CHANNEL : i_cfg_data[7:0];

    always_comb begin
        n_esc      = r_esc;
        n_synced   = r_synced;
        n_rx       = r_rx;
        n_tx       = r_tx;
        n_known    = r_known;
        has_result = 1'b0;
        job        = '0;
        unique case (t_cmd'(i_command))
            CMD_RECEIVE: begin
                priority if (i_data_byte == ECM_ESC_BYTE) begin
                    n_esc = 1'b1;
                end else if (r_esc && (i_data_byte < limit)) begin
                    n_esc = 1'b0;
                    if (enabled_vec[i_data_byte]) begin
                        n_rx     = i_data_byte;
                        n_synced = 1'b1;
                    end
                end else if (r_esc && (i_data_byte != ECM_LITERAL_CODE)) begin
                    // query: answer with the transmit channel if there is one
                    n_esc = 1'b0;
                    if (r_known) begin
                        has_result   = 1'b1;
                        job.bytes[0] = ECM_ESC_BYTE;
                        job.bytes[1] = r_tx;
                        job.last     = ECM_IDX_W'(1);
                    end
                end else begin
                    n_esc = 1'b0;
                    if (!(r_wait && !r_synced)) begin
                        has_result   = 1'b1;
                        job.dest     = 1'b1;
                        job.target   = r_rx;
                        job.bytes[0] = r_esc ? ECM_ESC_BYTE : i_data_byte;
                        job.last     = ECM_IDX_W'(0);
                    end
                end
            end
            CMD_SEND: begin
                if (i_source_channel != ECM_ESC_BYTE) begin
                    has_result = 1'b1;
                    if (!r_known || (r_tx != i_source_channel)) begin
                        n_tx         = i_source_channel;
                        n_known      = 1'b1;
                        job.bytes[0] = ECM_ESC_BYTE;
                        job.bytes[1] = i_source_channel;
                        job.bytes[2] = i_data_byte;
                        job.bytes[3] = ECM_ESC_BYTE;
                        job.last     = (i_data_byte == ECM_ESC_BYTE) ? ECM_IDX_W'(3)
                                                                      : ECM_IDX_W'(2);
                    end else begin
                        job.bytes[0] = i_data_byte;
                        job.bytes[1] = ECM_ESC_BYTE;
                        job.last     = (i_data_byte == ECM_ESC_BYTE) ? ECM_IDX_W'(1)
                                                                      : ECM_IDX_W'(0);
                    end
                end
            end
            CMD_SYNC: begin
                has_result   = 1'b1;
                job.bytes[0] = ECM_ESC_BYTE;
                job.bytes[1] = ECM_QUERY_CODE;
                job.bytes[2] = ECM_ESC_BYTE;
                job.bytes[3] = r_known ? r_tx : ECM_ESC_BYTE;
                job.last     = ECM_IDX_W'(3);
            end
            default: begin
            end
        endcase
        job.rxch = n_rx;
    end

    assign o_push = i_accept && has_result;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2      <= 1'b1;
            r_wait    <= 1'b0;
            r_enabled <= '0;
            r_esc     <= 1'b0;
            r_synced  <= 1'b0;
            r_rx      <= 8'd0;
            r_tx      <= 8'd0;
            r_known   <= 1'b0;
        end else if (i_accept) begin
            r_esc    <= n_esc;
            r_synced <= n_synced;
            r_rx     <= n_rx;
            r_tx     <= n_tx;
            r_known  <= n_known;
        end else if (i_cfg_write) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_V2_PROTOCOL:   r_v2  <= i_cfg_data[0];
                CFG_WAIT_FOR_SYNC: r_wait <= i_cfg_data[0];
                CFG_INITIAL_RX: begin
                    // only the live receive channel needs it, and only before any switch
                    if (!r_synced) begin
                        r_rx <= cfg_rx;
                    end
                end
                CFG_ENABLED_0: r_enabled[63:0]    <= i_cfg_data;
                CFG_ENABLED_1: r_enabled[127:64]  <= i_cfg_data;
                CFG_ENABLED_2: r_enabled[191:128] <= i_cfg_data;
                CFG_ENABLED_3: r_enabled[254:192] <= i_cfg_data[62:0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ design/ecm_queue.sv @@
// Job queue between the decoding front end and the byte emitter.
module ecm_queue
    import ecm_pkg::*;
#(
    parameter int DEPTH = ECM_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_head_valid,
    output t_job o_head
);

    `include "escape_coded_channel_mux_unit_macros.svh"

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if (p == PTR_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + PTR_W'(1);
        end
        return res;
    endfunction

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= next_ptr(r_wr);
            end
            if (i_pop) begin
                r_rd <= next_ptr(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `ECM_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "queue count beyond depth")
    `ECM_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "job pushed into a full queue")
    `ECM_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, o_head_valid, "job popped from an empty queue")

endmodule

@@ design/ecm_back.sv @@
// Back end: walks the head job one byte a cycle, while unstalled, into the output register.
module ecm_back
    import ecm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_job       i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_out_destination,
    output logic [7:0] o_out_target_channel,
    output logic [7:0] o_out_byte,
    output logic       o_out_last_of_run,
    output logic [7:0] o_out_receive_channel
);

    `include "escape_coded_channel_mux_unit_macros.svh"

    logic [ECM_IDX_W-1:0] r_idx;
    logic                 r_valid;
    logic                 r_dest;
    logic [7:0]           r_target;
    logic [7:0]           r_byte;
    logic                 r_last;
    logic [7:0]           r_rxch;

    logic load;
    logic at_last;

    assign load    = !r_valid || !i_out_stall;
    assign at_last = (r_idx == i_head.last);
    assign o_pop   = load && i_head_valid && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= i_head_valid;
            if (i_head_valid) begin
                r_idx <= at_last ? '0 : r_idx + ECM_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head_valid) begin
            r_dest   <= i_head.dest;
            r_target <= i_head.target;
            r_byte   <= i_head.bytes[r_idx];
            r_last   <= at_last;
            r_rxch   <= i_head.rxch;
        end
    end

    assign o_out_valid           = r_valid;
    assign o_out_destination     = r_dest;
    assign o_out_target_channel  = r_target;
    assign o_out_byte            = r_byte;
    assign o_out_last_of_run     = r_last;
    assign o_out_receive_channel = r_rxch;

    `ECM_ASSERT_NOW(a_idx_idle, i_clk, i_rst_n, !i_head_valid, r_idx == '0, "byte index left over with no job")
    `ECM_ASSERT_NOW(a_idx_bound, i_clk, i_rst_n, i_head_valid, r_idx <= i_head.last, "byte index beyond job end")
    `ECM_ASSERT_NOW(a_rx_single, i_clk, i_rst_n, r_valid && r_dest, r_last, "received data word not alone in its run")

endmodule

@@ design/escape_coded_channel_mux_unit.sv @@
// Top level of the escape-coded channel multiplexer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | into unit | i_in_valid / o_in_stall | command, data_byte, source_channel
//  out     | out       | o_out_valid / i_out_stall | destination, target_channel, out_byte,
//          |           |                        | last_of_run, receive_channel
//  cfg     | into unit | i_cfg_valid / o_cfg_ready | register index, 64-bit write data
//
// An input word is decoded in the cycle it is accepted; the link state updates at once,
// so a new word can enter every cycle while the queue has room.
// Each word yields zero to four output words, emitted by the back end one per cycle
// while the output is not stalled.
// From acceptance, a job passes the queue and then the output register before its first word shows.
// Reset is synchronous, active low, and clears link state, queue and output valid.
// A stalled output holds its word; the queue (QUEUE_DEPTH jobs) keeps the input open until full.
module escape_coded_channel_mux_unit
    import ecm_pkg::*;
#(
    parameter int QUEUE_DEPTH = ECM_QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input word channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_in_command,
    input  logic [7:0]                i_in_data_byte,
    input  logic [7:0]                i_in_source_channel,
    // output word channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_out_destination,
    output logic [7:0]                o_out_target_channel,
    output logic [7:0]                o_out_byte,
    output logic                      o_out_last_of_run,
    output logic [7:0]                o_out_receive_channel,
    // configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [ECM_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ECM_CFG_DATA_W-1:0] i_cfg_data
);

    logic in_accept;
    logic push;
    t_job job;
    logic full;
    logic head_valid;
    t_job head;
    logic pop;

    // Hold the input off only while the job queue is full.
    assign o_in_stall  = full;
    assign in_accept   = i_in_valid && !full;
    // Ready stays high; the user must write only while the unit is idle (not enforced).
    assign o_cfg_ready = 1'b1;

    ecm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_command        (i_in_command),
        .i_data_byte      (i_in_data_byte),
        .i_source_channel (i_in_source_channel),
        .i_cfg_write      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_push           (push),
        .o_job            (job)
    );

    ecm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    ecm_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_head_valid          (head_valid),
        .i_head                (head),
        .o_pop                 (pop),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_out_destination     (o_out_destination),
        .o_out_target_channel  (o_out_target_channel),
        .o_out_byte            (o_out_byte),
        .o_out_last_of_run     (o_out_last_of_run),
        .o_out_receive_channel (o_out_receive_channel)
    );

endmodule
